[hdl/dds_pkg.sv]
package dds_pkg;

    localparam int CORE_COUNT_DEF = 8;
    localparam int MAX_BURSTS_DEF = 64;

    typedef struct packed {
        logic [31:0] external_address;
        logic [31:0] local_address;
        logic [15:0] row_length;
        logic [15:0] rows_per_plane;
        logic [15:0] plane_count;
        logic [31:0] row_stride;
        logic [31:0] plane_stride;
        logic        to_external;
        logic        channel_transpose;
    } desc_t;

    typedef struct packed {
        logic        two_d;
        logic        direction;
        logic [31:0] total_bytes;
        logic [31:0] burst_external_address;
        logic [31:0] burst_local_address;
        logic [31:0] chunk_bytes;
        logic [31:0] chunk_stride;
        logic        last;
        logic        error;
    } burst_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic total;
        logic classify;
        logic div_step;
        logic share;
        logic clamp;
        logic offset;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic transpose;
        logic core_zero;
        logic empty;
        logic out_free;
        logic burst_last;
    } status_t;

endpackage

[hdl/dds_desc_if.sv]
interface dds_desc_if;
    logic            valid;
    logic            ready;
    dds_pkg::desc_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/dds_burst_if.sv]
interface dds_burst_if;
    logic             valid;
    logic             ready;
    dds_pkg::burst_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/dma_descriptor_splitter.sv]
// Splits one 3D copy descriptor into DMA burst commands.
// The desc channel takes one descriptor per transfer; the burst channel gives
// one burst command per transfer, with last set on the final burst of the
// descriptor. cfg_wr_en and cfg_wr_data write the core index at any clock edge.
// A descriptor is taken only when the splitter is idle. A plain descriptor on
// core zero goes through the setup steps plane size, total and shape decision
// before its first burst enters the output register. A transpose descriptor
// goes through the setup steps plane size, share by reciprocal multiplication,
// share start, clamp and offsets before its first burst enters the output
// register.
// After that one burst is produced per cycle while the output register is free,
// up to MAX_BURSTS bursts. A descriptor that ends in no burst returns to idle
// right after its setup. The next descriptor is accepted in the cycle after the
// last burst enters the output register, even while that burst still waits to
// be taken, so without stalls a descriptor occupies its setup, its bursts and
// the idle state. When the receiver stalls, the output register holds its burst
// and the burst generator waits. Reset empties the output register, returns the
// controller to idle and sets the core index to zero.
module dma_descriptor_splitter #(
    parameter int CORE_COUNT = dds_pkg::CORE_COUNT_DEF,
    parameter int MAX_BURSTS = dds_pkg::MAX_BURSTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    dds_desc_if.sink    desc,
    dds_burst_if.source burst
);
    import dds_pkg::*;

    // Commands from the controller and status back from the datapath.
    cmd_t    cmd;
    status_t status;

    dds_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc.valid),
        .desc_ready (desc.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath holds the descriptor, the core index, the shared
    // multiplier, the divider and the burst generator with its output register.
    dds_dp #(
        .CORE_COUNT (CORE_COUNT),
        .MAX_BURSTS (MAX_BURSTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .desc_data   (desc.data),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (burst.ready),
        .out_valid   (burst.valid),
        .out_data    (burst.data)
    );

endmodule

[hdl/dds_ctrl.sv]
module dds_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             desc_valid,
    output logic             desc_ready,
    input  dds_pkg::status_t status,
    output dds_pkg::cmd_t    cmd
);
    import dds_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_PREP     = 9'b000000010,
        S_TOTAL    = 9'b000000100,
        S_CLASSIFY = 9'b000001000,
        S_DIVIDE   = 9'b000010000,
        S_SHARE    = 9'b000100000,
        S_CLAMP    = 9'b001000000,
        S_OFFSET   = 9'b010000000,
        S_EMIT     = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (desc_valid)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                if (status.transpose)
                    state_next = S_DIVIDE;
                else if (status.core_zero)
                    state_next = S_TOTAL;
                else
                    state_next = S_IDLE;
            end
            S_TOTAL:    state_next = S_CLASSIFY;
            S_CLASSIFY: state_next = status.empty ? S_IDLE : S_EMIT;
            S_DIVIDE:   state_next = S_SHARE;
            S_SHARE:    state_next = S_CLAMP;
            S_CLAMP:    state_next = S_OFFSET;
            S_OFFSET:   state_next = status.empty ? S_IDLE : S_EMIT;
            S_EMIT:
            begin
                if (status.out_free && status.burst_last)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign desc_ready   = (state_reg == S_IDLE);
    assign cmd.load     = (state_reg == S_IDLE) && desc_valid;
    assign cmd.prep     = (state_reg == S_PREP);
    assign cmd.total    = (state_reg == S_TOTAL);
    assign cmd.classify = (state_reg == S_CLASSIFY);
    assign cmd.div_step = (state_reg == S_DIVIDE);
    assign cmd.share    = (state_reg == S_SHARE);
    assign cmd.clamp    = (state_reg == S_CLAMP);
    assign cmd.offset   = (state_reg == S_OFFSET);
    assign cmd.emit     = (state_reg == S_EMIT) && status.out_free;

endmodule

[hdl/dds_dp.sv]
module dds_dp #(
    parameter int CORE_COUNT = dds_pkg::CORE_COUNT_DEF,
    parameter int MAX_BURSTS = dds_pkg::MAX_BURSTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_wr_data,
    input  dds_pkg::desc_t    desc_data,
    input  dds_pkg::cmd_t     cmd,
    output dds_pkg::status_t  status,
    input  logic              out_ready,
    output logic              out_valid,
    output dds_pkg::burst_t   out_data
);
    import dds_pkg::*;

    localparam int RW = $clog2(MAX_BURSTS + 1);
    // Rounded-up reciprocal of the core count. With a shift of 23 the quotient is
    // exact for every 17-bit numerator and every core count up to 64.
    localparam logic [23:0]       RECIP     = 24'(((1 << 23) + CORE_COUNT - 1) / CORE_COUNT);
    localparam logic [16:0]       ROUND_UP  = 17'(CORE_COUNT - 1);
    localparam logic [15:0]       MAX_N     = 16'(MAX_BURSTS);

    // Burst generator state: current addresses, per-burst increments and
    // the fields that stay fixed over the bursts of one descriptor.
    typedef struct packed {
        logic [31:0] ext_acc;
        logic [31:0] loc_acc;
        logic [31:0] ext_step;
        logic [31:0] loc_step;
        logic [31:0] tot;
        logic [31:0] cb;
        logic [31:0] cs;
        logic        two_d;
        logic        err;
    } plan_t;

    localparam plan_t FAIL_PLAN = '{err: 1'b1, default: '0};

    desc_t             d_reg;
    logic [2:0]        core_reg;
    logic [31:0]       pb_reg;
    logic [31:0]       pb_next;
    logic [47:0]       prod_reg;
    logic [16:0]       num_reg;
    logic [16:0]       num_next;
    logic [18:0]       start_raw_reg;
    logic [15:0]       start_reg;
    logic [15:0]       start_next;
    logic [15:0]       n_raw_reg;
    logic [15:0]       n_raw_next;
    plan_t             plan_reg;
    plan_t             plan_next;
    logic [RW-1:0]     remain_reg;
    logic [RW-1:0]     remain_next;
    logic              out_valid_reg;
    burst_t            out_data_reg;

    logic [31:0] len32;
    logic [15:0] mul_b;
    logic [47:0] mul_full;
    logic [39:0] quot_full;
    logic        planes_one;
    logic        rs_eq_len;
    logic        one_d;
    logic        single;
    logic        cls_empty;
    logic [15:0] start_c;
    logic [16:0] stop_sum;
    logic [15:0] stop_c;
    logic        burst_last;
    logic        out_free;

    assign len32      = {16'b0, d_reg.row_length};
    assign mul_b      = cmd.offset ? start_reg : d_reg.plane_count;
    assign mul_full   = pb_reg * mul_b;
    assign planes_one = (d_reg.plane_count == 16'd1);
    assign rs_eq_len  = (d_reg.row_stride == len32);
    assign one_d      = (planes_one && (d_reg.rows_per_plane == 16'd1))
                     || (rs_eq_len && (pb_reg == d_reg.plane_stride))
                     || (planes_one && rs_eq_len);
    assign single     = planes_one || rs_eq_len;
    assign cls_empty  = !(one_d || single) && (d_reg.plane_count == 16'd0);

    // Division by the core count as a multiplication by its reciprocal.
    assign quot_full = 40'(num_reg) * 40'(RECIP);

    // The share of this core, clamped to the channel range.
    assign start_c  = (start_raw_reg > {3'b0, d_reg.row_length}) ? d_reg.row_length
                                                                 : start_raw_reg[15:0];
    assign stop_sum = {1'b0, start_c} + {1'b0, num_reg[15:0]};
    assign stop_c   = (stop_sum > {1'b0, d_reg.row_length}) ? d_reg.row_length
                                                            : stop_sum[15:0];

    assign burst_last = (remain_reg == RW'(1));
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        pb_next     = pb_reg;
        num_next    = num_reg;
        start_next  = start_reg;
        n_raw_next  = n_raw_reg;
        plan_next   = plan_reg;
        remain_next = remain_reg;

        if (cmd.prep)
        begin
            pb_next  = 32'(d_reg.rows_per_plane)
                     * 32'(d_reg.channel_transpose ? d_reg.plane_count : d_reg.row_length);
            num_next = {1'b0, d_reg.row_length} + ROUND_UP;
        end

        if (cmd.div_step)
            num_next = quot_full[39:23];

        if (cmd.clamp)
        begin
            start_next = start_c;
            n_raw_next = stop_c - start_c;
        end

        if (cmd.classify)
        begin
            remain_next = RW'(1);
            if (one_d || single)
            begin
                if (prod_reg[47:32] != 16'd0)
                    plan_next = FAIL_PLAN;
                else
                begin
                    plan_next          = '0;
                    plan_next.ext_acc  = d_reg.external_address;
                    plan_next.loc_acc  = d_reg.local_address;
                    plan_next.tot      = prod_reg[31:0];
                    plan_next.two_d    = !one_d;
                    if (one_d)
                    begin
                        plan_next.cb = '0;
                        plan_next.cs = '0;
                    end
                    else if (planes_one)
                    begin
                        plan_next.cb = len32;
                        plan_next.cs = d_reg.row_stride;
                    end
                    else
                    begin
                        plan_next.cb = pb_reg;
                        plan_next.cs = d_reg.plane_stride;
                    end
                end
            end
            else if (d_reg.plane_count > MAX_N)
                plan_next = FAIL_PLAN;
            else
            begin
                remain_next        = RW'(d_reg.plane_count);
                plan_next.ext_acc  = d_reg.external_address;
                plan_next.loc_acc  = d_reg.local_address;
                plan_next.ext_step = d_reg.plane_stride;
                plan_next.loc_step = pb_reg;
                plan_next.tot      = pb_reg;
                plan_next.cb       = len32;
                plan_next.cs       = d_reg.row_stride;
                plan_next.two_d    = 1'b1;
                plan_next.err      = 1'b0;
            end
        end

        if (cmd.offset)
        begin
            if (n_raw_reg > MAX_N)
            begin
                remain_next = RW'(1);
                plan_next   = FAIL_PLAN;
            end
            else
            begin
                remain_next        = RW'(n_raw_reg);
                plan_next.ext_acc  = d_reg.external_address + {16'b0, start_reg};
                plan_next.loc_acc  = d_reg.local_address + mul_full[31:0];
                plan_next.ext_step = 32'd1;
                plan_next.loc_step = pb_reg;
                plan_next.tot      = pb_reg;
                plan_next.cb       = 32'd1;
                plan_next.cs       = d_reg.row_stride;
                plan_next.two_d    = 1'b1;
                plan_next.err      = 1'b0;
            end
        end

        if (cmd.emit)
        begin
            plan_next.ext_acc = plan_reg.ext_acc + plan_reg.ext_step;
            plan_next.loc_acc = plan_reg.loc_acc + plan_reg.loc_step;
            remain_next       = remain_reg - RW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            d_reg <= desc_data;
        if (cmd.total)
            prod_reg <= mul_full;
        if (cmd.share)
            start_raw_reg <= 19'(num_reg[15:0]) * 19'(core_reg);
        pb_reg     <= pb_next;
        num_reg    <= num_next;
        start_reg  <= start_next;
        n_raw_reg  <= n_raw_next;
        plan_reg   <= plan_next;
        remain_reg <= remain_next;
        if (cmd.emit)
        begin
            out_data_reg.two_d                  <= plan_reg.two_d;
            out_data_reg.direction              <= d_reg.to_external;
            out_data_reg.total_bytes            <= plan_reg.tot;
            out_data_reg.burst_external_address <= plan_reg.ext_acc;
            out_data_reg.burst_local_address    <= plan_reg.loc_acc;
            out_data_reg.chunk_bytes            <= plan_reg.cb;
            out_data_reg.chunk_stride           <= plan_reg.cs;
            out_data_reg.last                   <= burst_last;
            out_data_reg.error                  <= plan_reg.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                core_reg <= cfg_wr_data;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.transpose  = d_reg.channel_transpose;
    assign status.core_zero  = (core_reg == 3'd0);
    assign status.empty      = cmd.classify ? cls_empty
                                            : ((n_raw_reg == 16'd0) && (n_raw_reg <= MAX_N));
    assign status.out_free   = out_free;
    assign status.burst_last = burst_last;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[tb/dma_descriptor_splitter_tb.sv]
`timescale 1ns / 100ps

module dma_descriptor_splitter_tb;

    import dds_pkg::*;

    // The splitter is built with its default sizes, and the predictor uses the same ones.
    localparam int CORE_COUNT = CORE_COUNT_DEF;
    localparam int MAX_BURSTS = MAX_BURSTS_DEF;

    // Each side idles in about this many cycles out of a hundred.
    localparam int IDLE_PERCENT = 12;
    // A transpose descriptor has the longest setup. A descriptor that gives no burst
    // can still be in setup when the last expected burst has arrived. The splitter is
    // therefore given this many quiet cycles before the core index changes and before
    // the run ends.
    localparam int SETTLE_CYCLES = 40;
    // Upper bound on the wait for outstanding bursts at a quiet point.
    localparam int DRAIN_LIMIT = 20000;
    // Upper bound on the whole run, in clock cycles.
    localparam int CYCLE_LIMIT = 1000000;
    // Random descriptors per phase. Descriptors that the splitter ignores are not counted.
    localparam int PHASE_ITEMS = 40;
    localparam int PHASE_COUNT = 8;

    // A directed row with this count is checked against the predictor. Any other count
    // is the number of typed-in bursts (zero or one) that the row must produce.
    localparam int FROM_PREDICTOR = -1;

    // Descriptor shapes for the random part. Most of them are well-formed shapes
    // that reach each branch of the splitter, and the rest is noise.
    typedef enum int {
        SHAPE_TRANSPOSE,
        SHAPE_CONTIGUOUS,
        SHAPE_ONE_PLANE,
        SHAPE_BACK_TO_BACK,
        SHAPE_PER_PLANE,
        SHAPE_NOISE
    } shape_t;

    typedef struct {
        logic [2:0] core;
        desc_t      d;
        int         known_count;
        burst_t     known_burst;
    } directed_case_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [2:0] cfg_wr_data;

    dds_desc_if  desc_ch ();
    dds_burst_if burst_ch ();

    dma_descriptor_splitter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .desc        (desc_ch),
        .burst       (burst_ch)
    );

    // The testbench's own copy of the core index. It changes only at quiet points.
    logic [2:0] core_sel;

    // Bursts that the accepted descriptors must still produce, oldest first.
    burst_t pending_bursts[$];
    directed_case_t directed_cases[$];

    // These travel with each descriptor, so that the monitor sees the ones that
    // belong to the descriptor of the transfer that it observes.
    int     sent_known_count;
    burst_t sent_known_burst;

    // While calm is set, neither side idles.
    bit calm;
    int mismatches = 0;
    int cycle_count = 0;
    burst_t want_burst;
    logic [2:0] phase_cores [PHASE_COUNT];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic burst_t make_burst(input logic two_d, input logic dir,
                                          input logic [31:0] total, input logic [31:0] ext,
                                          input logic [31:0] loc, input logic [31:0] chunk,
                                          input logic [31:0] stride, input logic last_flag,
                                          input logic err_flag);
        burst_t b;
        b.two_d                  = two_d;
        b.direction              = dir;
        b.total_bytes            = total;
        b.burst_external_address = ext;
        b.burst_local_address    = loc;
        b.chunk_bytes            = chunk;
        b.chunk_stride           = stride;
        b.last                   = last_flag;
        b.error                  = err_flag;
        return b;
    endfunction

    // Works out the bursts that one descriptor gives on the given core and queues them.
    task automatic predict_bursts(input desc_t d, input logic [2:0] core);
        logic [63:0] len;
        logic [63:0] rows;
        logic [63:0] planes;
        logic [63:0] rstride;
        logic [63:0] pstride;
        logic [63:0] share;
        logic [63:0] first_ch;
        logic [63:0] stop_ch;
        logic [63:0] count;
        logic [63:0] plane_bytes;
        logic [63:0] total;
        logic [63:0] ch;
        logic [63:0] ext_offset;
        logic [63:0] loc_offset;
        logic one_d;
        logic single_2d;
        int i;
        len     = 64'(d.row_length);
        rows    = 64'(d.rows_per_plane);
        planes  = 64'(d.plane_count);
        rstride = 64'(d.row_stride);
        pstride = 64'(d.plane_stride);
        if (d.channel_transpose)
        begin
            // Channels are shared out by ceiling division. A core past the end of
            // the channels gets an empty share and gives nothing.
            share = (len + CORE_COUNT - 1) / CORE_COUNT;
            first_ch = share * core;
            if (first_ch > len)
                first_ch = len;
            stop_ch = first_ch + share;
            if (stop_ch > len)
                stop_ch = len;
            count = stop_ch - first_ch;
            plane_bytes = rows * planes;
            if (count > MAX_BURSTS)
                pending_bursts.push_back(make_burst(1'b0, d.to_external, '0, '0, '0, '0, '0,
                                                    1'b1, 1'b1));
            else
                for (i = 0; i < int'(count); i++)
                begin
                    ch = first_ch + 64'(i);
                    loc_offset = plane_bytes * ch;
                    pending_bursts.push_back(make_burst(1'b1, d.to_external,
                                                        plane_bytes[31:0],
                                                        d.external_address + ch[31:0],
                                                        d.local_address + loc_offset[31:0],
                                                        32'd1, d.row_stride,
                                                        64'(i + 1) == count, 1'b0));
                end
        end
        else if (core == 3'd0)
        begin
            // Only core zero moves plain copies; other cores stay silent.
            plane_bytes = rows * len;
            total = plane_bytes * planes;
            one_d = (planes == 1 && rows == 1) || (rstride == len && plane_bytes == pstride) ||
                    (planes == 1 && len == rstride);
            single_2d = (planes == 1) || (len == rstride);
            if (one_d || single_2d)
            begin
                if (total > 64'hFFFF_FFFF)
                    pending_bursts.push_back(make_burst(1'b0, d.to_external, '0, '0, '0, '0,
                                                        '0, 1'b1, 1'b1));
                else if (one_d)
                    pending_bursts.push_back(make_burst(1'b0, d.to_external, total[31:0],
                                                        d.external_address, d.local_address,
                                                        '0, '0, 1'b1, 1'b0));
                else if (planes == 1)
                    pending_bursts.push_back(make_burst(1'b1, d.to_external, total[31:0],
                                                        d.external_address, d.local_address,
                                                        32'(d.row_length), d.row_stride,
                                                        1'b1, 1'b0));
                else
                    pending_bursts.push_back(make_burst(1'b1, d.to_external, total[31:0],
                                                        d.external_address, d.local_address,
                                                        plane_bytes[31:0], d.plane_stride,
                                                        1'b1, 1'b0));
            end
            else if (planes > MAX_BURSTS)
                pending_bursts.push_back(make_burst(1'b0, d.to_external, '0, '0, '0, '0, '0,
                                                    1'b1, 1'b1));
            else
                // One strided burst per plane; zero planes give nothing at all.
                for (i = 0; i < int'(planes); i++)
                begin
                    ext_offset = pstride * 64'(i);
                    loc_offset = plane_bytes * 64'(i);
                    pending_bursts.push_back(make_burst(1'b1, d.to_external,
                                                        plane_bytes[31:0],
                                                        d.external_address + ext_offset[31:0],
                                                        d.local_address + loc_offset[31:0],
                                                        32'(d.row_length), d.row_stride,
                                                        64'(i + 1) == planes, 1'b0));
                end
        end
    endtask

    task automatic add_case(input logic [2:0] core, input logic [31:0] ext,
                            input logic [31:0] loc, input logic [15:0] len,
                            input logic [15:0] rows, input logic [15:0] planes,
                            input logic [31:0] rstride, input logic [31:0] pstride,
                            input logic dir, input logic transpose, input int known_count,
                            input burst_t known_burst);
        directed_case_t c;
        c.core                = core;
        c.d.external_address  = ext;
        c.d.local_address     = loc;
        c.d.row_length        = len;
        c.d.rows_per_plane    = rows;
        c.d.plane_count       = planes;
        c.d.row_stride        = rstride;
        c.d.plane_stride      = pstride;
        c.d.to_external       = dir;
        c.d.channel_transpose = transpose;
        c.known_count         = known_count;
        c.known_burst         = known_burst;
        directed_cases.push_back(c);
    endtask

    function automatic desc_t random_desc(input logic [2:0] core);
        desc_t d;
        shape_t shape;
        int pick;
        d.external_address  = $urandom;
        d.local_address     = $urandom;
        d.row_length        = 16'($urandom_range(1, 64));
        d.rows_per_plane    = 16'($urandom_range(0, 12));
        d.plane_count       = 16'($urandom_range(0, 12));
        d.row_stride        = $urandom;
        d.plane_stride      = $urandom;
        d.to_external       = 1'($urandom_range(0, 1));
        d.channel_transpose = 1'b0;
        // Cores other than zero ignore plain copies, so they mostly get transposes.
        pick = (core != 3'd0 && $urandom_range(0, 3) != 0) ? 0 : $urandom_range(0, 9);
        if (pick < 3)
            shape = SHAPE_TRANSPOSE;
        else if (pick == 3)
            shape = SHAPE_CONTIGUOUS;
        else if (pick == 4)
            shape = SHAPE_ONE_PLANE;
        else if (pick == 5)
            shape = SHAPE_BACK_TO_BACK;
        else if (pick < 9)
            shape = SHAPE_PER_PLANE;
        else
            shape = SHAPE_NOISE;
        case (shape)
            SHAPE_TRANSPOSE:
            begin
                d.channel_transpose = 1'b1;
                // Up to 560 channels, so a full share can go past the burst limit.
                d.row_length = 16'($urandom_range(1, 560));
                if ($urandom_range(0, 7) == 0)
                    d.row_length = 16'($urandom);
                if ($urandom_range(0, 7) == 0)
                    d.rows_per_plane = 16'($urandom);
                if ($urandom_range(0, 7) == 0)
                    d.plane_count = 16'($urandom);
            end
            SHAPE_CONTIGUOUS:
            begin
                d.row_stride   = 32'(d.row_length);
                d.plane_stride = 32'(d.row_length) * 32'(d.rows_per_plane);
            end
            SHAPE_ONE_PLANE:
            begin
                d.plane_count = 16'd1;
                if ($urandom_range(0, 3) == 0)
                    d.rows_per_plane = 16'd1;
            end
            SHAPE_BACK_TO_BACK:
            begin
                d.row_stride = 32'(d.row_length);
            end
            SHAPE_PER_PLANE:
            begin
                // Now and then a plane count from 60 to 70, around the burst limit.
                d.plane_count = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(60, 70))
                                                            : 16'($urandom_range(2, 64));
            end
            default:
            begin
                d.row_length        = 16'($urandom);
                d.rows_per_plane    = 16'($urandom);
                d.plane_count       = 16'($urandom);
                d.channel_transpose = 1'($urandom_range(0, 1));
            end
        endcase
        return d;
    endfunction

    // Offers one descriptor and holds it until it is taken, then idles at random.
    task automatic send_desc(input desc_t d, input int known_count, input burst_t known_burst);
        desc_ch.valid    <= 1'b1;
        desc_ch.data     <= d;
        sent_known_count <= known_count;
        sent_known_burst <= known_burst;
        @(posedge clk);
        while (!desc_ch.ready)
            @(posedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            desc_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Waits until every expected burst has arrived and the splitter has had time to
    // finish a descriptor that gives no burst. Bursts that never came are failures.
    task automatic wait_quiet();
        int waited;
        waited = 0;
        desc_ch.valid <= 1'b0;
        while (pending_bursts.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_bursts.size() != 0)
        begin
            $error("%0d expected bursts never arrived", pending_bursts.size());
            mismatches += pending_bursts.size();
            pending_bursts.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic change_core(input logic [2:0] core);
        wait_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= core;
        core_sel    <= core;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            mismatches++;
        end
    endtask

    // The receiver stalls in about one cycle of eight, except in the calm stretch.
    always @(posedge clk)
        burst_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);

    // Monitor: each accepted descriptor adds its bursts to the queue, and each burst
    // transfer is compared with the oldest burst in the queue.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (desc_ch.valid && desc_ch.ready)
            begin
                if (sent_known_count == FROM_PREDICTOR)
                    predict_bursts(desc_ch.data, core_sel);
                else if (sent_known_count == 1)
                    pending_bursts.push_back(sent_known_burst);
            end
            if (burst_ch.valid && burst_ch.ready)
            begin
                if (pending_bursts.size() == 0)
                begin
                    $error("burst transfer with no burst expected");
                    mismatches++;
                end
                else
                begin
                    want_burst = pending_bursts.pop_front();
                    check_field("two_d", 32'(want_burst.two_d), 32'(burst_ch.data.two_d));
                    check_field("direction", 32'(want_burst.direction),
                                32'(burst_ch.data.direction));
                    check_field("total_bytes", want_burst.total_bytes,
                                burst_ch.data.total_bytes);
                    check_field("burst_external_address", want_burst.burst_external_address,
                                burst_ch.data.burst_external_address);
                    check_field("burst_local_address", want_burst.burst_local_address,
                                burst_ch.data.burst_local_address);
                    check_field("chunk_bytes", want_burst.chunk_bytes,
                                burst_ch.data.chunk_bytes);
                    check_field("chunk_stride", want_burst.chunk_stride,
                                burst_ch.data.chunk_stride);
                    check_field("last", 32'(want_burst.last), 32'(burst_ch.data.last));
                    check_field("error", 32'(want_burst.error), 32'(burst_ch.data.error));
                end
            end
        end
    end

    // A run that hangs ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** dma_descriptor_splitter: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= 3'd0;
        desc_ch.valid    <= 1'b0;
        desc_ch.data     <= '0;
        sent_known_count <= FROM_PREDICTOR;
        sent_known_burst <= '0;
        core_sel         <= 3'd0;
        calm             = 1'b0;

        // Directed descriptors. Where the result is plain to see, it is typed in.
        // Core zero: a single row is one 1D burst, at the low and the high extremes.
        add_case(3'd0, 32'h1000, 32'h200, 16'd64, 16'd1, 16'd1, 32'd0, 32'd0, 1'b0, 1'b0, 1,
                 make_burst(1'b0, 1'b0, 32'd64, 32'h1000, 32'h200, '0, '0, 1'b1, 1'b0));
        add_case(3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd1, 16'd1, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 1'b1, 1'b0, 1,
                 make_burst(1'b0, 1'b1, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0,
                            1'b1, 1'b0));
        // Rows and planes that lie back to back collapse into one 1D burst.
        add_case(3'd0, 32'h8000_0000, 32'h40, 16'd16, 16'd4, 16'd3, 32'd16, 32'd64, 1'b0,
                 1'b0, 1,
                 make_burst(1'b0, 1'b0, 32'd192, 32'h8000_0000, 32'h40, '0, '0, 1'b1, 1'b0));
        // One plane with strided rows.
        add_case(3'd0, 32'h100, 32'h0, 16'd8, 16'd5, 16'd1, 32'd100, 32'd0, 1'b1, 1'b0, 1,
                 make_burst(1'b1, 1'b1, 32'd40, 32'h100, 32'h0, 32'd8, 32'd100, 1'b1, 1'b0));
        // Back-to-back rows in strided planes: the whole plane is one chunk.
        add_case(3'd0, 32'h2000, 32'h300, 16'd10, 16'd3, 16'd4, 32'd10, 32'd1000, 1'b0,
                 1'b0, 1,
                 make_burst(1'b1, 1'b0, 32'd120, 32'h2000, 32'h300, 32'd30, 32'd1000, 1'b1,
                            1'b0));
        // One burst per plane, then the burst limit with both addresses wrapping.
        add_case(3'd0, 32'h4000, 32'h500, 16'd4, 16'd2, 16'd3, 32'd32, 32'h100, 1'b0, 1'b0,
                 FROM_PREDICTOR, '0);
        add_case(3'd0, 32'hFFFF_FF00, 32'hFFFF_FFF0, 16'd5, 16'd3, 16'd64, 32'd7, 32'h80,
                 1'b1, 1'b0, FROM_PREDICTOR, '0);
        // One plane too many for the burst limit.
        add_case(3'd0, 32'h4000, 32'h500, 16'd4, 16'd2, 16'd65, 32'd32, 32'h100, 1'b1, 1'b0,
                 1, make_burst(1'b0, 1'b1, '0, '0, '0, '0, '0, 1'b1, 1'b1));
        // Byte totals past 32 bits, for a 1D burst and for a single 2D burst.
        add_case(3'd0, 32'h10, 32'h20, 16'hFFFF, 16'hFFFF, 16'd2, 32'hFFFF, 32'hFFFE_0001,
                 1'b0, 1'b0, 1, make_burst(1'b0, 1'b0, '0, '0, '0, '0, '0, 1'b1, 1'b1));
        add_case(3'd0, 32'h10, 32'h20, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF, 32'd0, 1'b1,
                 1'b0, 1, make_burst(1'b0, 1'b1, '0, '0, '0, '0, '0, 1'b1, 1'b1));
        // Zero sizes: empty planes and empty rows are passed on, and no planes at all give no burst.
        add_case(3'd0, 32'h600, 32'h700, 16'd16, 16'd0, 16'd5, 32'd20, 32'd50, 1'b0, 1'b0,
                 FROM_PREDICTOR, '0);
        add_case(3'd0, 32'h600, 32'h700, 16'd3, 16'd2, 16'd0, 32'd9, 32'd0, 1'b1, 1'b0, 0,
                 '0);
        add_case(3'd0, 32'h800, 32'h900, 16'd0, 16'd4, 16'd2, 32'd0, 32'd0, 1'b0, 1'b0, 1,
                 make_burst(1'b0, 1'b0, 32'd0, 32'h800, 32'h900, '0, '0, 1'b1, 1'b0));
        // Transposes on core zero: one channel, a full share at the limit, one too many.
        add_case(3'd0, 32'hA00, 32'hB00, 16'd8, 16'd3, 16'd4, 32'd48, 32'd0, 1'b1, 1'b1,
                 FROM_PREDICTOR, '0);
        add_case(3'd0, 32'hFFFF_FFE0, 32'hFFFF_0000, 16'd512, 16'd2, 16'd3, 32'hFFFF_FFFF,
                 32'd0, 1'b0, 1'b1, FROM_PREDICTOR, '0);
        add_case(3'd0, 32'hA00, 32'hB00, 16'd513, 16'd2, 16'd3, 32'd16, 32'd0, 1'b0, 1'b1,
                 1, make_burst(1'b0, 1'b0, '0, '0, '0, '0, '0, 1'b1, 1'b1));
        // The highest core ignores plain copies and takes the tail of the channels.
        add_case(3'd7, 32'h1000, 32'h200, 16'd64, 16'd1, 16'd1, 32'd0, 32'd0, 1'b0, 1'b0, 0,
                 '0);
        add_case(3'd7, 32'hC00, 32'hD00, 16'd8, 16'd4, 16'd4, 32'd64, 32'd0, 1'b1, 1'b1,
                 FROM_PREDICTOR, '0);
        add_case(3'd7, 32'hC00, 32'hD00, 16'd50, 16'd2, 16'd2, 32'd100, 32'd0, 1'b0, 1'b1,
                 FROM_PREDICTOR, '0);
        add_case(3'd7, 32'hC00, 32'hD00, 16'd40, 16'd3, 16'd1, 32'd80, 32'd0, 1'b1, 1'b1,
                 FROM_PREDICTOR, '0);
        // Too few channels to reach this core: an empty share gives nothing.
        add_case(3'd7, 32'hC00, 32'hD00, 16'd3, 16'd3, 16'd1, 32'd80, 32'd0, 1'b1, 1'b1, 0,
                 '0);
        // A middle core: a huge share, the largest plane size, and an empty plane.
        add_case(3'd3, 32'hE00, 32'hF00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd1, 32'd0, 1'b1,
                 1'b1, 1, make_burst(1'b0, 1'b1, '0, '0, '0, '0, '0, 1'b1, 1'b1));
        add_case(3'd3, 32'hFFFF_FFFE, 32'hF000_0000, 16'd30, 16'hFFFF, 16'hFFFF, 32'd5,
                 32'd0, 1'b0, 1'b1, FROM_PREDICTOR, '0);
        add_case(3'd3, 32'hE00, 32'hF00, 16'd30, 16'd0, 16'd9, 32'd5, 32'd0, 1'b1, 1'b1,
                 FROM_PREDICTOR, '0);
        add_case(3'd0, 32'h0, 32'h0, 16'd1, 16'd1, 16'd1, 32'd0, 32'd0, 1'b0, 1'b1,
                 FROM_PREDICTOR, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cases[k])
        begin
            if (directed_cases[k].core != core_sel)
                change_core(directed_cases[k].core);
            send_desc(directed_cases[k].d, directed_cases[k].known_count,
                      directed_cases[k].known_burst);
        end

        // Random phases, each on the core index given for it, with the extremes among them.
        // The third phase runs without any idling on either side.
        phase_cores = '{3'd0, 3'd7, 3'd0, 3'd1, 3'd4, 3'd0, 3'd2, 3'd0};
        phase_cores[PHASE_COUNT - 1] = 3'($urandom_range(0, 7));
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            change_core(phase_cores[p]);
            calm = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; )
            begin
                desc_t d;
                d = random_desc(core_sel);
                send_desc(d, FROM_PREDICTOR, '0);
                if (d.channel_transpose || core_sel == 3'd0)
                    n++;
            end
        end
        calm = 1'b0;

        wait_quiet();
        if (mismatches == 0)
            $display("** dma_descriptor_splitter: PASSED **");
        else
            $display("** dma_descriptor_splitter: FAILED **");
        $finish;
    end

endmodule

[sim.f]
hdl/dds_pkg.sv
hdl/dds_desc_if.sv
hdl/dds_burst_if.sv
hdl/dds_ctrl.sv
hdl/dds_dp.sv
hdl/dma_descriptor_splitter.sv
tb/dma_descriptor_splitter_tb.sv
